// File: sv/ssrm_pkg.sv
// Shared types, constants and helpers for the separator-search record marker.
`timescale 1ns / 1ps

package ssrm_pkg;

  // Configuration register indexes
  localparam logic [1:0] CFG_SEP_LEN   = 2'd0;
  localparam logic [1:0] CFG_SEP_BYTES = 2'd1;
  localparam logic [1:0] CFG_SEP_AT_END = 2'd2;

  // Result kinds
  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_MARK = 1'b1;

  localparam logic [7:0] CHAR_CR  = 8'h0D;
  localparam logic [7:0] CHAR_LF  = 8'h0A;
  localparam logic [7:0] CHAR_NUL = 8'h00;

  // Live configuration; sep_len is already clamped to the maximum length
  typedef struct packed {
    logic [3:0]  sep_len;
    logic [63:0] sep_bytes;
    logic        at_end;
  } cfg_t;

  // One queued command: held prefix to flush, optional raw byte, optional match burst
  typedef struct packed {
    logic [2:0] prefix_cnt;
    logic       emit_byte;
    logic [7:0] byte_val;
    logic       match;
  } cmd_t;

  function automatic logic [7:0] sep_byte(input logic [63:0] bytes, input logic [2:0] idx);
    sep_byte = bytes[{idx, 3'b000} +: 8];
  endfunction

endpackage

// File: sv/ssrm_front.sv
// Front end: matches each input byte against the separator and issues commands.
`timescale 1ns / 1ps

module ssrm_front import ssrm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       held_clr_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       full_i,
  output logic       push_o,
  output cmd_t       cmd_o
);

  logic [2:0] held_q, held_d;
  logic [3:0] held_eff;
  logic [3:0] nxt;
  logic [7:0] tail;
  logic       hit;
  logic       accept;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && !full_i;

  always_comb begin
    held_eff = ({1'b0, held_q} >= cfg_i.sep_len) ? 4'd0 : {1'b0, held_q};
    tail     = sep_byte(cfg_i.sep_bytes, 3'(cfg_i.sep_len - 4'd1));
    hit      = (in_byte_i == sep_byte(cfg_i.sep_bytes, held_eff[2:0]));
    cmd_o    = '0;
    cmd_o.byte_val = in_byte_i;
    nxt      = 4'd0;
    push_o   = 1'b0;
    if (cfg_i.sep_len == 4'd0) begin
      // no separator: straight pass-through
      cmd_o.emit_byte = 1'b1;
      push_o          = accept;
    end else if (cfg_i.at_end && in_byte_i == CHAR_NUL && held_eff == 4'd0 &&
                 (tail == CHAR_CR || tail == CHAR_LF)) begin
      // with separator at end and a CR/LF last separator byte, a NUL is dropped while no partial match is held
      nxt = 4'd0;
    end else begin
      if (!hit) begin
        cmd_o.prefix_cnt = held_eff[2:0];
        if (in_byte_i != sep_byte(cfg_i.sep_bytes, 3'd0)) begin
          cmd_o.emit_byte = 1'b1;
          nxt             = 4'd0;
        end else begin
          nxt = 4'd1;
        end
      end else begin
        nxt = held_eff + 4'd1;
      end
      if (nxt == cfg_i.sep_len) begin
        cmd_o.match = 1'b1;
        nxt         = 4'd0;
      end
      push_o = accept && (cmd_o.prefix_cnt != 3'd0 || cmd_o.emit_byte || cmd_o.match);
    end
    held_d = held_q;
    if (held_clr_i) begin
      held_d = 3'd0;
    end else if (accept) begin
      held_d = nxt[2:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= 3'd0;
    end else begin
      held_q <= held_d;
    end
  end

  a_clr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_clr_i |=> held_q == 3'd0)
    else $error("held count not cleared on length write");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_i |-> !push_o)
    else $error("command pushed into full queue");

endmodule

// File: sv/ssrm_queue.sv
// Small command queue between front end and back end.
`timescale 1ns / 1ps

module ssrm_queue import ssrm_pkg::*; #(
  parameter int unsigned DEPTH = 4
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  input  logic pop_i,
  output cmd_t head_o,
  output logic empty_o,
  output logic full_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  cmd_t            mem_q [DEPTH];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign empty_o = (cnt_q == CntW'(0));
  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign head_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PtrW'(DEPTH - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == PtrW'(DEPTH - 1)) ? '0 : rd_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(DEPTH))
    else $error("queue count out of range");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("pop from empty queue");

endmodule

// File: sv/ssrm_back.sv
// Back end: expands each queued command into result items, one per cycle unless the output stalls.
`timescale 1ns / 1ps

module ssrm_back import ssrm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  cmd_t       cmd_i,
  input  logic       empty_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       kind_o,
  output logic [7:0] value_o,
  output logic       last_o
);

  logic [3:0] step_q, step_d;
  logic       vld_q, vld_d;
  logic       kind_q, kind_d;
  logic [7:0] value_q, value_d;
  logic       last_q, last_d;

  logic [3:0] base;
  logic [4:0] total;
  logic [3:0] mi;
  logic       s_kind;
  logic [7:0] s_value;
  logic       s_last;
  logic       adv;

  // result at the current step of the head command
  always_comb begin
    base  = {1'b0, cmd_i.prefix_cnt} + {3'b000, cmd_i.emit_byte};
    total = {1'b0, base} + (cmd_i.match ? ({1'b0, cfg_i.sep_len} + 5'd1) : 5'd0);
    mi    = step_q - base;
    s_kind  = KIND_DATA;
    s_value = 8'd0;
    if (step_q < {1'b0, cmd_i.prefix_cnt}) begin
      s_value = sep_byte(cfg_i.sep_bytes, step_q[2:0]);
    end else if (cmd_i.emit_byte && step_q == {1'b0, cmd_i.prefix_cnt}) begin
      s_value = cmd_i.byte_val;
    end else if (!cfg_i.at_end) begin
      if (mi == 4'd0) begin
        s_kind = KIND_MARK;
      end else begin
        s_value = sep_byte(cfg_i.sep_bytes, 3'(mi - 4'd1));
      end
    end else begin
      if (mi < cfg_i.sep_len) begin
        s_value = sep_byte(cfg_i.sep_bytes, mi[2:0]);
      end else begin
        s_kind = KIND_MARK;
      end
    end
    s_last = ({1'b0, step_q} == total - 5'd1);
  end

  assign adv   = !vld_q || out_ready_i;
  assign pop_o = adv && !empty_i && s_last;

  always_comb begin
    step_d  = step_q;
    vld_d   = vld_q;
    kind_d  = kind_q;
    value_d = value_q;
    last_d  = last_q;
    if (adv) begin
      vld_d = !empty_i;
      if (!empty_i) begin
        kind_d  = s_kind;
        value_d = s_value;
        last_d  = s_last;
        step_d  = s_last ? 4'd0 : step_q + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= 4'd0;
      vld_q  <= 1'b0;
    end else begin
      step_q <= step_d;
      vld_q  <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q  <= kind_d;
    value_q <= value_d;
    last_q  <= last_d;
  end

  assign out_valid_o = vld_q;
  assign kind_o      = kind_q;
  assign value_o     = value_q;
  assign last_o      = last_q;

  a_step_needs_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q != 4'd0 |-> !empty_i)
    else $error("mid-command step with empty queue");

  a_mark_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q && kind_q == KIND_MARK |-> value_q == 8'd0)
    else $error("marker with nonzero value");

endmodule

// File: sv/sync_string_record_marker.sv
// Top level of the separator-search record marker.
`timescale 1ns / 1ps
//
//  channel  dir  handshake              payload
//  -------  ---  ---------------------  -------------------------------------
//  in       in   in_valid_i/in_ready_o  in_byte_i[7:0]
//  out      out  out_valid_o/out_ready_i kind_o, value_o[7:0], last_o
//  cfg      in   cfg_valid_i/cfg_ready_o cfg_index_i[1:0], cfg_data_i[63:0]
//
//  Front end takes one byte per cycle while the command queue has room.
//  Back end emits one result item per cycle unless stalled: a byte gives 1 to
//  9 items (held prefix, raw byte, marker plus separator), which set drain time.
//  A byte that only extends a partial match, or a dropped NUL, gives no item.
//  Reset clears the match count, queue and output valid; config resets to
//  length 0, bytes 0, separator-at-end 1. Config writes are always taken.
//  Output stalls back up through the queue to in_ready_o.

module sync_string_record_marker import ssrm_pkg::*; #(
  parameter int unsigned MAX_SEP     = 8,
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  in_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        kind_o,
  output logic [7:0]  value_o,
  output logic        last_o
);

  logic [3:0]  sep_len_q, sep_len_d;
  logic [63:0] sep_bytes_q, sep_bytes_d;
  logic        at_end_q, at_end_d;
  logic        cfg_wr;
  logic        held_clr;
  cfg_t        cfg;

  logic push, pop, empty, full;
  cmd_t cmd_in, cmd_head;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i;
  // a new length throws away any held partial match
  assign held_clr    = cfg_wr && cfg_index_i == CFG_SEP_LEN;

  always_comb begin
    sep_len_d   = sep_len_q;
    sep_bytes_d = sep_bytes_q;
    at_end_d    = at_end_q;
    if (cfg_wr) begin
      case (cfg_index_i)
        CFG_SEP_LEN:    sep_len_d   = cfg_data_i[3:0];
        CFG_SEP_BYTES:  sep_bytes_d = cfg_data_i;
        CFG_SEP_AT_END: at_end_d    = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sep_len_q   <= 4'd0;
      sep_bytes_q <= 64'd0;
      at_end_q    <= 1'b1;
    end else begin
      sep_len_q   <= sep_len_d;
      sep_bytes_q <= sep_bytes_d;
      at_end_q    <= at_end_d;
    end
  end

  // oversized length acts as the maximum
  always_comb begin
    cfg.sep_len   = (sep_len_q > 4'(MAX_SEP)) ? 4'(MAX_SEP) : sep_len_q;
    cfg.sep_bytes = sep_bytes_q;
    cfg.at_end    = at_end_q;
  end

  ssrm_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .held_clr_i (held_clr),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_byte_i  (in_byte_i),
    .full_i     (full),
    .push_o     (push),
    .cmd_o      (cmd_in)
  );

  ssrm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd_in),
    .pop_i   (pop),
    .head_o  (cmd_head),
    .empty_o (empty),
    .full_o  (full)
  );

  ssrm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .cmd_i       (cmd_head),
    .empty_i     (empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .kind_o      (kind_o),
    .value_o     (value_o),
    .last_o      (last_o)
  );

endmodule
